[sv/stb_pkg.sv]
package stb_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned FLAG_W = 2;
  localparam int unsigned MASK_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_ARM   = 3'd3,
    OP_CHECK = 3'd4
  } op_e;

  typedef struct packed {
    logic cap;
    logic exec;
    logic cmp;
    logic load;
  } cmd_t;

  typedef struct packed {
    op_e op;
  } stat_t;

endpackage

[sv/stb_ram.sv]
module stb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/stb_ctrl.sv]
module stb_ctrl import stb_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  stat_t         stat_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] cmp_idx_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic [AW-1:0] cmp_idx_q;
  logic          cmp_vld_q;
  logic          out_valid_q;
  logic          accept;
  logic          out_free;
  logic          load;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cnt_q <= '0;
          if (stat_i.op == OP_CHECK) begin
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= 1'b1;
          cmp_idx_q <= cnt_q;
          cnt_q     <= cnt_q + AW'(1);
          if (cnt_q == AW'(NUM_TIMERS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          cmp_vld_q <= 1'b0;
          state_q   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rd_addr_o   = cnt_q;
  assign cmp_idx_o   = cmp_idx_q;

  assign cmd_o.cap  = accept;
  assign cmd_o.exec = (state_q == ST_EXEC);
  assign cmd_o.cmp  = cmp_vld_q;
  assign cmd_o.load = load;

`ifndef NO_ASSERTIONS
  a_cmp_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
    else $error("compare stage active outside scan");

  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> cmp_vld_q && (cmp_idx_q == AW'(NUM_TIMERS - 1)))
    else $error("drain entered before last entry");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted transfer not executed");

  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("result load did not complete");
`endif

endmodule

[sv/stb_dp.sv]
module stb_dp import stb_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     cmp_idx_i,
  output stat_t             stat_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [ID_W-1:0]   timer_id_i,
  input  logic [TIME_W-1:0] period_i,
  input  logic [FLAG_W-1:0] flags_i,
  input  logic [TIME_W-1:0] now_i,
  output logic [MASK_W-1:0] fired_mask_o,
  output logic [MASK_W-1:0] active_mask_o
);

  localparam int unsigned MW = (NUM_TIMERS > MASK_W) ? NUM_TIMERS : MASK_W;
  localparam int unsigned XW = AW + ID_W;

  op_e               op_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] per_q;
  logic [FLAG_W-1:0] flags_q;
  logic [TIME_W-1:0] now_q;

  logic [NUM_TIMERS-1:0] act_q;
  logic [NUM_TIMERS-1:0] perd_q;
  logic [NUM_TIMERS-1:0] reg_q;
  logic [NUM_TIMERS-1:0] wvld_q;
  logic [NUM_TIMERS-1:0] fired_q;
  logic [MASK_W-1:0]     out_fired_q;
  logic [MASK_W-1:0]     out_active_q;

  logic [XW-1:0]     id_ext;
  logic [AW-1:0]     id_idx;
  logic              id_ok;
  logic              wr_exec;
  logic              hit;
  logic [TIME_W-1:0] dl_rdata;
  logic [TIME_W-1:0] per_rdata;
  logic [TIME_W-1:0] dl_eff;
  logic [TIME_W-1:0] per_eff;
  logic [TIME_W-1:0] sum_exec;
  logic [TIME_W-1:0] sum_reload;
  logic              dl_we;
  logic [AW-1:0]     dl_waddr;
  logic [TIME_W-1:0] dl_wdata;
  logic [MW-1:0]     fired_ext;
  logic [MW-1:0]     active_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= op_e'(op_i);
      id_q    <= timer_id_i;
      per_q   <= period_i;
      flags_q <= flags_i;
      now_q   <= now_i;
    end
  end

  assign id_ext  = {AW'(0), id_q};
  assign id_idx  = id_ext[AW-1:0];
  assign id_ok   = id_ext < XW'(NUM_TIMERS);
  assign wr_exec = cmd_i.exec && id_ok && ((op_q == OP_INIT) || (op_q == OP_ARM));

  assign dl_eff     = wvld_q[cmp_idx_i] ? dl_rdata : '0;
  assign per_eff    = wvld_q[cmp_idx_i] ? per_rdata : '0;
  assign hit        = cmd_i.cmp && reg_q[cmp_idx_i] && act_q[cmp_idx_i] && (now_q >= dl_eff);
  assign sum_exec   = now_q + per_q;
  assign sum_reload = now_q + per_eff;

  assign dl_we    = wr_exec || (hit && perd_q[cmp_idx_i]);
  assign dl_waddr = wr_exec ? id_idx : cmp_idx_i;
  assign dl_wdata = wr_exec ? sum_exec : sum_reload;

  stb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (dl_rdata)
  );

  stb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (wr_exec),
    .waddr_i (id_idx),
    .wdata_i (per_q),
    .raddr_i (rd_addr_i),
    .rdata_o (per_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= '0;
      perd_q  <= '0;
      reg_q   <= '0;
      wvld_q  <= '0;
      fired_q <= '0;
    end else begin
      if (cmd_i.cap) begin
        fired_q <= '0;
      end
      if (wr_exec) begin
        wvld_q[id_idx] <= 1'b1;
      end
      if (cmd_i.exec && id_ok) begin
        case (op_q)
          OP_INIT: begin
            act_q[id_idx]  <= flags_q[0];
            perd_q[id_idx] <= flags_q[1];
          end
          OP_START: begin
            reg_q[id_idx] <= 1'b1;
            act_q[id_idx] <= 1'b1;
          end
          OP_STOP: begin
            if (reg_q[id_idx]) begin
              act_q[id_idx] <= 1'b0;
            end
          end
          OP_ARM: begin
            if (flags_q[1]) begin
              perd_q[id_idx] <= 1'b1;
            end
            reg_q[id_idx] <= 1'b1;
            act_q[id_idx] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (hit) begin
        fired_q[cmp_idx_i] <= 1'b1;
        if (!perd_q[cmp_idx_i]) begin
          act_q[cmp_idx_i] <= 1'b0;
        end
      end
    end
  end

  assign fired_ext  = MW'(fired_q);
  assign active_ext = MW'(act_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_fired_q  <= fired_ext[MASK_W-1:0];
      out_active_q <= active_ext[MASK_W-1:0];
    end
  end

  assign stat_o.op     = op_q;
  assign fired_mask_o  = out_fired_q;
  assign active_mask_o = out_active_q;

endmodule

[sv/software_timer_bank_unit.sv]
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   op, timer_id, period, flags, now
// out       output     out_valid_o / out_stall_i fired_mask, active_mask
//
// Init, start, stop, arm and unknown ops go through the execute and done states to the result.
// Check also passes through the scan and drain states, reading the deadline and period
// RAMs one entry per cycle during the scan.
// Reset clears all flags and entry valid bits at once; no clearing pass.
// A new transfer is taken while a finished result waits; its result then holds.
module software_timer_bank_unit import stb_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [ID_W-1:0]   in_timer_id_i,
  input  logic [TIME_W-1:0] in_period_i,
  input  logic [FLAG_W-1:0] in_flags_i,
  input  logic [TIME_W-1:0] in_now_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MASK_W-1:0] out_fired_mask_o,
  output logic [MASK_W-1:0] out_active_mask_o
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] cmp_idx;

  stb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .cmp_idx_o   (cmp_idx)
  );

  stb_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .cmp_idx_i     (cmp_idx),
    .stat_o        (stat),
    .op_i          (in_op_i),
    .timer_id_i    (in_timer_id_i),
    .period_i      (in_period_i),
    .flags_i       (in_flags_i),
    .now_i         (in_now_i),
    .fired_mask_o  (out_fired_mask_o),
    .active_mask_o (out_active_mask_o)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb import stb_pkg::*;;

  localparam int unsigned NUM_TIMERS  = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = NUM_TIMERS + 12;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam int unsigned RAND_ITEMS  = 1150;
  localparam int unsigned FLOOD_ITEMS = 40;
  localparam logic [OP_W-1:0] OP_LAST = '1;
  localparam logic [TIME_W-1:0] T_MAX = '1;

  typedef struct packed {
    logic [MASK_W-1:0] fired;
    logic [MASK_W-1:0] active;
  } timer_masks_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_op;
  logic [ID_W-1:0] in_timer_id;
  logic [TIME_W-1:0] in_period;
  logic [FLAG_W-1:0] in_flags;
  logic [TIME_W-1:0] in_now;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MASK_W-1:0] out_fired_mask;
  logic [MASK_W-1:0] out_active_mask;

  logic [TIME_W-1:0] tmr_deadline [NUM_TIMERS];
  logic [TIME_W-1:0] tmr_period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tmr_active;
  logic [NUM_TIMERS-1:0] tmr_periodic;
  logic [NUM_TIMERS-1:0] tmr_registered;

  timer_masks_t pending_masks_q[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  logic [TIME_W-1:0] sys_now;

  always #10 clk = ~clk;

  software_timer_bank_unit #(
    .NUM_TIMERS(NUM_TIMERS)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_op_i          (in_op),
    .in_timer_id_i    (in_timer_id),
    .in_period_i      (in_period),
    .in_flags_i       (in_flags),
    .in_now_i         (in_now),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_fired_mask_o (out_fired_mask),
    .out_active_mask_o(out_active_mask)
  );

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic predict_timer_masks(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] per,
                                     input logic [FLAG_W-1:0] fl,
                                     input logic [TIME_W-1:0] now);
    timer_masks_t res;
    res.fired = '0;
    if (op == OP_CHECK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (tmr_registered[i] && tmr_active[i] && now >= tmr_deadline[i]) begin
          if (tmr_periodic[i]) tmr_deadline[i] = now + tmr_period[i];
          else tmr_active[i] = 1'b0;
          if (i < MASK_W) res.fired[i] = 1'b1;
        end
      end
    end else if (id < NUM_TIMERS) begin
      case (op)
        OP_INIT: begin
          tmr_period[id] = per;
          tmr_deadline[id] = now + per;
          tmr_active[id] = fl[0];
          tmr_periodic[id] = fl[1];
        end
        OP_START: begin
          tmr_registered[id] = 1'b1;
          tmr_active[id] = 1'b1;
        end
        OP_STOP: begin
          if (tmr_registered[id]) tmr_active[id] = 1'b0;
        end
        OP_ARM: begin
          tmr_period[id] = per;
          tmr_deadline[id] = now + per;
          if (fl[1]) tmr_periodic[id] = 1'b1;
          tmr_registered[id] = 1'b1;
          tmr_active[id] = 1'b1;
        end
        default: ;
      endcase
    end
    res.active = tmr_active[MASK_W-1:0];
    pending_masks_q.push_back(res);
  endtask

  task automatic send_timer_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] per, input logic [FLAG_W-1:0] fl,
                               input logic [TIME_W-1:0] now);
    in_valid <= 1'b1;
    in_op <= op;
    in_timer_id <= id;
    in_period <= per;
    in_flags <= fl;
    in_now <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer_masks(op, id, per, fl, now);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic paced_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] per, input logic [FLAG_W-1:0] fl,
                          input logic [TIME_W-1:0] now);
    send_timer_op(op, id, per, fl, now);
    pace_sender();
  endtask

  task automatic test_register_and_stop();
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, '0);
    paced_op(OP_INIT, 4'd0, T_MAX, 2'b01, '0);
    paced_op(OP_STOP, 4'd0, '0, 2'b00, '0);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, T_MAX);
    paced_op(OP_START, 4'd0, '0, 2'b00, '0);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, T_MAX);
    paced_op(OP_INIT, 4'd15, '0, 2'b10, T_MAX);
    paced_op(OP_START, 4'd15, '0, 2'b00, '0);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, T_MAX);
    paced_op(OP_STOP, 4'd15, '0, 2'b00, '0);
  endtask

  task automatic test_arm_and_expiry();
    paced_op(OP_ARM, 4'd7, 32'd10, 2'b00, 32'd100);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, 32'd109);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, 32'd110);
    paced_op(OP_ARM, 4'd3, 32'd5, 2'b10, 32'd200);
    paced_op(OP_ARM, 4'd3, 32'd8, 2'b00, 32'd200);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, 32'd208);
    paced_op(OP_ARM, 4'd9, 32'h20, 2'b11, 32'hFFFF_FFF0);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, 32'h10);
  endtask

  task automatic test_patterns_and_unknown_ops();
    paced_op(OP_INIT, 4'd12, 32'h5555_5555, 2'b11, 32'hAAAA_AAAA);
    for (int op = OP_CHECK + 1; op <= OP_LAST; op++)
      paced_op(OP_W'(op), 4'd12, T_MAX, 2'b11, T_MAX);
    paced_op(OP_INIT, 4'd3, 32'hAAAA_AAAA, 2'b00, 32'h5555_5555);
    paced_op(OP_CHECK, 4'd0, '0, 2'b00, T_MAX);
  endtask

  task automatic random_timer_op();
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] per;
    logic [FLAG_W-1:0] fl;
    logic [TIME_W-1:0] now;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, NUM_TIMERS - 1));
    per = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 40);
    fl = FLAG_W'($urandom_range(0, 3));
    now = sys_now;
    sys_now = sys_now + $urandom_range(0, 5);
    if (sel < 35) op = OP_CHECK;
    else if (sel < 60) op = OP_ARM;
    else if (sel < 70) op = OP_INIT;
    else if (sel < 80) op = OP_START;
    else if (sel < 90) op = OP_STOP;
    else if (sel < 94) op = OP_W'($urandom_range(OP_CHECK + 1, OP_LAST));
    else begin
      op = OP_W'($urandom_range(0, OP_LAST));
      per = $urandom();
      now = $urandom();
    end
    send_timer_op(op, id, per, fl, now);
  endtask

  task automatic test_random_traffic();
    sys_now = $urandom_range(0, 1000);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) sys_now = T_MAX - $urandom_range(100, 400);
      random_timer_op();
      pace_sender();
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int n = 0; n < FLOOD_ITEMS; n++) random_timer_op();
  endtask

  always @(posedge clk) begin
    timer_masks_t exp_masks;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_masks_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result fired %h active %h",
                                  out_fired_mask, out_active_mask));
      end else begin
        exp_masks = pending_masks_q.pop_front();
        if (out_fired_mask !== exp_masks.fired)
          report_mismatch($sformatf("fired_mask got %h expected %h",
                                    out_fired_mask, exp_masks.fired));
        if (out_active_mask !== exp_masks.active)
          report_mismatch($sformatf("active_mask got %h expected %h",
                                    out_active_mask, exp_masks.active));
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    phase = 0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        if (hold_requests != holds_done) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          holds_done++;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (phase % 5 >= 3);
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned waited;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_INIT;
    in_timer_id <= '0;
    in_period <= '0;
    in_flags <= '0;
    in_now <= '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_deadline[i] = '0;
      tmr_period[i] = '0;
    end
    tmr_active = '0;
    tmr_periodic = '0;
    tmr_registered = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_and_stop();
    test_arm_and_expiry();
    test_patterns_and_unknown_ops();
    test_random_traffic();
    test_backpressure();

    in_valid <= 1'b0;
    waited = 0;
    while (pending_masks_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_masks_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_masks_q.size()));
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
sv/stb_pkg.sv
sv/stb_ram.sv
sv/stb_ctrl.sv
sv/stb_dp.sv
sv/software_timer_bank_unit.sv
test/tb.sv
